FILE: rtl/dfs_pkg.sv
// dfs_pkg: shared constants, opcodes and item types for the dfs spanning forest block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

    localparam int VERTEX_SLOTS = 32;
    localparam int VTX_W        = 6;
    localparam int IDX_W        = $clog2(VERTEX_SLOTS);

    typedef logic [VTX_W-1:0]        t_vtx;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [VERTEX_SLOTS-1:0] t_row;

    typedef enum logic [1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_RUN      = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        t_vtx       vertex_a;
        t_vtx       vertex_b;
    } t_in_item;

    typedef struct packed {
        t_vtx vertex;
        t_vtx parent_vertex;
        logic last;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/dfs_lowbit.sv
// dfs_lowbit: lowest set bit search over one adjacency-wide word, result as vertex number
// depends on dfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfs_lowbit
    import dfs_pkg::*;
(
    input  wire t_row i_bits,
    output logic      o_found,
    output t_vtx      o_vertex
);

    always_comb begin
        o_found  = |i_bits;
        o_vertex = '0;
        for (int i = VERTEX_SLOTS - 1; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_vertex = VTX_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dfs_spanning_forest.sv
// dfs_spanning_forest: adjacency matrix store, depth-first search sequencer and result stage
// depends on dfs_pkg and dfs_lowbit
`timescale 1ns / 1ps
`default_nettype none

// For a run item over the n vertices in use, one shared lowest-bit search unit is
// stepped once per root pick plus one final empty pick, once per push and once
// per pop (each vertex is pushed and popped exactly once), then one result per
// vertex leaves through the output register, held back while the output is
// stalled. The input is stalled for the whole run.
module dfs_spanning_forest
    import dfs_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_we,
    input  wire t_vtx      i_cfg_data,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output t_out_item      o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROOT = 4'b0010,
        S_WALK = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    t_vtx      r_vertex_count;
    t_vtx      r_n, n_n;
    t_vtx      r_depth, n_depth;
    t_vtx      r_emit, n_emit;
    t_row      r_visited, n_visited;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;
    t_row      r_adj [VERTEX_SLOTS];
    t_vtx      r_stack [VERTEX_SLOTS];
    t_vtx      r_parent [VERTEX_SLOTS];

    logic      in_accept;
    logic      a_ok, b_ok;
    t_vtx      eff_n;
    t_row      in_use;
    t_vtx      top;
    t_row      lb_in;
    logic      lb_found;
    t_vtx      lb_vertex;
    t_idx      lb_idx;
    logic      emit_load;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign a_ok      = (i_in.vertex_a >= VTX_W'(1)) && (i_in.vertex_a <= VTX_W'(VERTEX_SLOTS));
    assign b_ok      = (i_in.vertex_b >= VTX_W'(1)) && (i_in.vertex_b <= VTX_W'(VERTEX_SLOTS));
    assign eff_n     = (r_vertex_count > VTX_W'(VERTEX_SLOTS)) ? VTX_W'(VERTEX_SLOTS)
                                                               : r_vertex_count;
    assign in_use    = ~({VERTEX_SLOTS{1'b1}} << r_n);
    assign top       = r_stack[IDX_W'(r_depth - VTX_W'(1))];
    assign lb_in     = (r_state == S_WALK) ? (r_adj[IDX_W'(top - VTX_W'(1))] & ~r_visited & in_use)
                                           : (~r_visited & in_use);
    assign lb_idx    = IDX_W'(lb_vertex - VTX_W'(1));
    assign emit_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    dfs_lowbit u_lowbit (
        .i_bits   (lb_in),
        .o_found  (lb_found),
        .o_vertex (lb_vertex)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_depth     = r_depth;
        n_emit      = r_emit;
        n_visited   = r_visited;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (t_op'(i_in.operation) == OP_RUN) && (eff_n != '0)) begin
                    n_n       = eff_n;
                    n_visited = '0;
                    n_state   = S_ROOT;
                end
            end
            S_ROOT: begin
                if (lb_found) begin
                    n_visited = r_visited | (t_row'(1) << lb_idx);
                    n_depth   = VTX_W'(1);
                    n_state   = S_WALK;
                end else begin
                    n_emit  = VTX_W'(1);
                    n_state = S_EMIT;
                end
            end
            S_WALK: begin
                if (lb_found) begin
                    n_visited = r_visited | (t_row'(1) << lb_idx);
                    n_depth   = r_depth + VTX_W'(1);
                end else begin
                    n_depth = r_depth - VTX_W'(1);
                    if (r_depth == VTX_W'(1)) begin
                        n_state = S_ROOT;
                    end
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_out_valid = 1'b1;
                    n_emit      = r_emit + VTX_W'(1);
                    if (r_emit == r_n) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= VTX_W'(VERTEX_SLOTS);
            r_n            <= '0;
            r_depth        <= '0;
            r_emit         <= '0;
            r_visited      <= '0;
            r_out_valid    <= 1'b0;
            r_adj          <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_depth     <= n_depth;
            r_emit      <= n_emit;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_data;
            end
            if (in_accept && (t_op'(i_in.operation) == OP_CLEAR)) begin
                r_adj <= '{default: '0};
            end else if (in_accept && (t_op'(i_in.operation) == OP_ADD_EDGE) && a_ok && b_ok) begin
                r_adj[IDX_W'(i_in.vertex_a - VTX_W'(1))][IDX_W'(i_in.vertex_b - VTX_W'(1))] <= 1'b1;
                r_adj[IDX_W'(i_in.vertex_b - VTX_W'(1))][IDX_W'(i_in.vertex_a - VTX_W'(1))] <= 1'b1;
            end
        end
    end

    // stack, parents and result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_ROOT) && lb_found) begin
            r_stack[0]       <= lb_vertex;
            r_parent[lb_idx] <= '0;
        end
        if ((r_state == S_WALK) && lb_found) begin
            r_stack[IDX_W'(r_depth)] <= lb_vertex;
            r_parent[lb_idx]         <= top;
        end
        if (emit_load) begin
            r_out.vertex        <= r_emit;
            r_out.parent_vertex <= r_parent[IDX_W'(r_emit - VTX_W'(1))];
            r_out.last          <= (r_emit == r_n);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_walk_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_depth != '0) && (r_depth <= r_n)))
        else $error("walk with empty or oversized stack");

    a_all_visited_at_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && (r_emit == VTX_W'(1))) |-> ((r_visited & in_use) == in_use))
        else $error("emit started with unvisited vertex");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |-> ((r_emit >= VTX_W'(1)) && (r_emit <= r_n)))
        else $error("emitted vertex out of range");

endmodule

`default_nettype wire

FILE: tb/dfs_spanning_forest_test.sv
// dfs_spanning_forest_test: self-checking testbench for the dfs spanning forest block
// predicts every (vertex, parent) result with its own depth-first walk over an adjacency copy
// depends on dfs_pkg and the dfs_spanning_forest rtl
`timescale 1ns / 1ps

module dfs_spanning_forest_test;
    import dfs_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE       = 4 * VERTEX_SLOTS + 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 38;

    class parent_tracker;
        t_row      adj [VERTEX_SLOTS];
        int        vertex_limit;
        t_out_item pending [$];
        int        error_count;

        function new();
            foreach (adj[i]) adj[i] = '0;
            vertex_limit = VERTEX_SLOTS;
            error_count  = 0;
        endfunction

        function void set_count(t_vtx value);
            vertex_limit = value;
        endfunction

        function void note_item(t_in_item item);
            t_row      seen;
            t_row      in_use;
            t_row      cand;
            t_vtx      parent [VERTEX_SLOTS];
            int        walk [VERTEX_SLOTS];
            int        n;
            int        depth;
            int        top;
            int        next;
            int        root;
            int        v;
            t_out_item res;
            case (t_op'(item.operation))
                OP_ADD_EDGE: begin
                    if (item.vertex_a >= 1 && item.vertex_a <= VERTEX_SLOTS &&
                        item.vertex_b >= 1 && item.vertex_b <= VERTEX_SLOTS) begin
                        adj[item.vertex_a - 1][item.vertex_b - 1] = 1'b1;
                        adj[item.vertex_b - 1][item.vertex_a - 1] = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    foreach (adj[i]) adj[i] = '0;
                end
                OP_RUN: begin
                    n = (vertex_limit > VERTEX_SLOTS) ? VERTEX_SLOTS : vertex_limit;
                    if (n > 0) begin
                        in_use = {VERTEX_SLOTS{1'b1}} >> (VERTEX_SLOTS - n);
                        seen   = '0;
                        for (root = 1; root <= n; root++) begin
                            if (!seen[root - 1]) begin
                                seen[root - 1]   = 1'b1;
                                parent[root - 1] = '0;
                                walk[0] = root;
                                depth   = 1;
                                while (depth > 0) begin
                                    top  = walk[depth - 1];
                                    cand = adj[top - 1] & ~seen & in_use;
                                    next = 0;
                                    for (v = VERTEX_SLOTS; v >= 1; v--)
                                        if (cand[v - 1]) next = v;
                                    if (next == 0) begin
                                        depth--;
                                    end else begin
                                        seen[next - 1]   = 1'b1;
                                        parent[next - 1] = t_vtx'(top);
                                        walk[depth]      = next;
                                        depth++;
                                    end
                                end
                            end
                        end
                        for (v = 1; v <= n; v++) begin
                            res.vertex        = t_vtx'(v);
                            res.parent_vertex = parent[v - 1];
                            res.last          = (v == n);
                            pending.push_back(res);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_parent(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                $error("result for vertex %0d with none expected", got.vertex);
                error_count++;
                return;
            end
            want = pending.pop_front();
            if (got.vertex !== want.vertex) begin
                $error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
                error_count++;
            end
            if (got.parent_vertex !== want.parent_vertex) begin
                $error("parent_vertex: expected %0d, got %0d",
                       want.parent_vertex, got.parent_vertex);
                error_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                error_count++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_we;
    t_vtx      cfg_data;
    logic      in_valid;
    logic      o_in_stall;
    t_in_item  in_item;
    logic      o_out_valid;
    logic      out_stall;
    t_out_item o_out;

    parent_tracker parents = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int sent_items     = 0;

    dfs_spanning_forest u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && out_stall === 1'b0)
            parents.check_parent(o_out);
    end

    // called and left at a falling edge
    task automatic send_item(input t_op op, input t_vtx a, input t_vtx b);
        t_in_item item;
        item.operation = op;
        item.vertex_a  = a;
        item.vertex_b  = b;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        parents.note_item(item);
        if (op != OP_NONE) sent_items++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (parents.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input t_vtx value);
        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        parents.set_count(value);
    endtask

    // clear (mostly), a handful of edges inside span, then a run
    task automatic send_graph_and_run(input int span);
        int k;
        int a;
        int b;
        bit chain;
        if ($urandom_range(3) != 0) send_item(OP_CLEAR, t_vtx'($urandom_range(63)),
                                              t_vtx'($urandom_range(63)));
        k     = $urandom_range(1, 12);
        chain = ($urandom_range(3) == 0);
        a     = $urandom_range(1, span);
        repeat (k) begin
            if (chain) begin
                b = (a < span) ? a + 1 : 1;
            end else begin
                a = $urandom_range(1, span);
                b = $urandom_range(1, span);
            end
            send_item(OP_ADD_EDGE, t_vtx'(a), t_vtx'(b));
            if (chain) a = b;
        end
        send_item(OP_RUN, t_vtx'($urandom_range(63)), t_vtx'($urandom_range(63)));
    endtask

    initial begin
        int   ph;
        int   span;
        bit   paused;
        t_vtx count_now;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty graph, field extremes, self loop, ignored endpoints, counts
        send_item(OP_RUN, 6'd0, 6'd63);
        send_item(OP_ADD_EDGE, 6'd1, 6'd2);
        send_item(OP_ADD_EDGE, 6'd3, 6'd2);
        send_item(OP_ADD_EDGE, 6'd1, 6'd32);
        send_item(OP_ADD_EDGE, 6'd32, 6'd32);
        send_item(OP_ADD_EDGE, 6'd0, 6'd5);
        send_item(OP_ADD_EDGE, 6'd5, 6'd0);
        send_item(OP_ADD_EDGE, 6'd63, 6'd1);
        send_item(OP_ADD_EDGE, 6'd4, 6'd63);
        send_item(OP_ADD_EDGE, 6'd33, 6'd4);
        send_item(OP_ADD_EDGE, 6'd31, 6'd30);
        send_item(OP_NONE, 6'd63, 6'd63);
        send_item(OP_RUN, 6'd0, 6'd0);
        write_vertex_count(6'd3);
        send_item(OP_RUN, 6'd63, 6'd0);
        write_vertex_count(6'd0);
        send_item(OP_RUN, 6'd0, 6'd0);
        write_vertex_count(6'd63);
        send_item(OP_RUN, 6'd0, 6'd0);
        write_vertex_count(6'd1);
        send_item(OP_RUN, 6'd0, 6'd0);
        write_vertex_count(6'd32);
        send_item(OP_CLEAR, 6'd0, 6'd0);
        send_item(OP_RUN, 6'd0, 6'd0);

        paused = 1'b0;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: count_now = 6'd32;
                1: count_now = t_vtx'($urandom_range(2, 31));
                2: count_now = t_vtx'($urandom_range(1, 8));
                default: count_now = t_vtx'($urandom_range(0, 63));
            endcase
            write_vertex_count(count_now);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            sent_items = 0;
            while (sent_items < PHASE_ITEMS) begin
                span = (count_now == 0 || count_now > VERTEX_SLOTS) ? VERTEX_SLOTS
                                                                    : count_now;
                if ($urandom_range(4) == 0) span = VERTEX_SLOTS;
                if ($urandom_range(9) < 8)
                    send_graph_and_run(span);
                else
                    send_item(t_op'($urandom_range(3)), t_vtx'($urandom_range(63)),
                              t_vtx'($urandom_range(63)));
                if (ph == 1 && !paused && sent_items > PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        if (parents.error_count == 0 && parents.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
